>>> hdl/rdsd_pkg.sv
`timescale 1ns / 1ps

package rdsd_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hfd;
    localparam logic [BYTE_W-1:0] START_MARK = 8'hfe;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'hff;
    localparam logic [BYTE_W-1:0] STUFF_FD   = 8'h00;
    localparam logic [BYTE_W-1:0] STUFF_FE   = 8'h01;

    localparam logic [POS_W-1:0] LEN_POS   = 9'd4;
    localparam logic [POS_W-1:0] LEN_EXTRA = 9'd8;
    localparam logic [POS_W-1:0] MAX_POS   = 9'd262;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  byte_position;
        logic              last_of_frame;
        logic              end_marker_ok;
    } rdsd_result_t;

    // escaped byte after 0xfd maps back onto one of the reserved codes
    function automatic logic [BYTE_W-1:0] destuff(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = END_MARK;
        if (b == STUFF_FD)
        begin
            r = ESC_BYTE;
        end
        else if (b == STUFF_FE)
        begin
            r = START_MARK;
        end
        return r;
    endfunction

endpackage

>>> hdl/rdsd_frame_core.sv
`timescale 1ns / 1ps

module rdsd_frame_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [rdsd_pkg::BYTE_W-1:0]  in_byte,
    output logic                         in_ready,
    input  logic                         buf_full,
    output logic                         res_push,
    output rdsd_pkg::rdsd_result_t       res
);
    import rdsd_pkg::*;

    logic              hold_valid_reg, hold_valid_next;
    logic [BYTE_W-1:0] hold_byte_reg;
    logic              esc_reg, esc_next;
    logic              inside_reg, inside_next;
    logic [POS_W-1:0]  index_reg, index_next;
    logic [POS_W-1:0]  total_reg, total_next;

    logic              is_esc;
    logic [BYTE_W-1:0] b;
    logic              has_result;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  total_cur;
    logic              last;
    logic              advance;
    logic              accept;

    always_comb
    begin
        is_esc     = (hold_byte_reg == ESC_BYTE);
        b          = esc_reg ? destuff(hold_byte_reg) : hold_byte_reg;
        has_result = !is_esc && (inside_reg || (b == START_MARK));
        pos        = inside_reg ? index_reg : '0;
        total_cur  = inside_reg ? total_reg : '0;
        if (pos == LEN_POS)
        begin
            total_cur = POS_W'({1'b0, b}) + LEN_EXTRA;
        end
        last = (pos >= LEN_POS) &&
               (({1'b0, pos} + 10'd1) >= {1'b0, total_cur});

        advance  = hold_valid_reg && (!has_result || !buf_full);
        in_ready = !hold_valid_reg || advance;
        accept   = in_valid && in_ready;

        hold_valid_next = accept ? 1'b1 : (advance ? 1'b0 : hold_valid_reg);
        esc_next    = esc_reg;
        inside_next = inside_reg;
        index_next  = index_reg;
        total_next  = total_reg;
        if (advance)
        begin
            esc_next = is_esc;
            if (has_result)
            begin
                inside_next = !last;
                index_next  = last ? '0 : pos + 9'd1;
                total_next  = total_cur;
            end
        end

        res_push          = advance && has_result;
        res.frame_byte    = b;
        res.byte_position = pos;
        res.last_of_frame = last;
        res.end_marker_ok = last && (b == END_MARK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            esc_reg        <= 1'b0;
            inside_reg     <= 1'b0;
            index_reg      <= '0;
            total_reg      <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            esc_reg        <= esc_next;
            inside_reg     <= inside_next;
            index_reg      <= index_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= in_byte;
        end
    end

endmodule

>>> hdl/rdsd_out_buf.sv
`timescale 1ns / 1ps

module rdsd_out_buf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rdsd_pkg::rdsd_result_t  push_data,
    output logic                    full,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rdsd_pkg::rdsd_result_t  out_data
);
    import rdsd_pkg::*;

    rdsd_result_t head_reg, head_next;
    rdsd_result_t tail_reg, tail_next;
    logic [1:0]   count_reg, count_next;
    logic         pop;

    always_comb
    begin
        pop       = out_valid && out_ready;
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = push_data;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
        else if (pop)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

>>> hdl/rds_byte_destuff_deframer_top.sv
`timescale 1ns / 1ps

// rds byte destuffer and frame extractor: takes one stuffed rds stream byte per
// transaction on the slave side and sustains one byte per clock. a 0xfd byte
// is an escape and produces nothing; the following byte is decoded as 0xfd
// (for 0x00), 0xfe (for 0x01) or 0xff (anything else). bytes are dropped until
// a 0xfe start marker, then every frame byte leaves on the master side with its
// position; frame byte 4 is the length and the frame is that value plus 8 bytes
// long. tlast marks the final byte and tuser says it matched the 0xff end
// marker. master tvalid rises after the byte has passed the input hold register
// and then the output register; throughput is set by the single decode stage and
// the two-entry output buffer, which keeps s_tready independent of m_tready so a
// back-pressured output stalls the input only once two results are waiting
// and the held byte would make a third.

module rds_byte_destuff_deframer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rdsd_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] raw_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rdsd_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [7:0] frame_byte, [16:8] byte_position, rest zero
    output logic                               m_tlast,  // last_of_frame
    output logic                               m_tuser   // end_marker_ok
);
    import rdsd_pkg::*;

    rdsd_result_t core_res;
    rdsd_result_t out_res;
    logic         core_push;
    logic         buf_full;

    // decode stage: escape handling, frame hunt, position and length tracking
    rdsd_frame_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata[BYTE_W-1:0]),
        .in_ready (s_tready),
        .buf_full (buf_full),
        .res_push (core_push),
        .res      (core_res)
    );

    // output register pair decoupling the two handshakes
    rdsd_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_push),
        .push_data (core_res),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {(OUT_TDATA_W - BYTE_W - POS_W)'(0), out_res.byte_position,
                      out_res.frame_byte};
    assign m_tlast = out_res.last_of_frame;
    assign m_tuser = out_res.end_marker_ok;

    // never push a result into a full buffer
    assert property (@(posedge clk) disable iff (!rst_n) core_push |-> !buf_full)
        else $error("result pushed into full output buffer");

    // input only stalls when the output buffer is full
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> buf_full)
        else $error("input stalled while output buffer has room");

    // end marker flag only on the last byte of a frame
    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && !m_tlast) |-> !m_tuser)
        else $error("end marker flag on a non-final byte");

    // position never exceeds the longest possible frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:8] <= MAX_POS))
        else $error("byte position out of range");

endmodule

>>> tb/rds_byte_destuff_deframer_top_tb.sv
`timescale 1ns / 1ps

module rds_byte_destuff_deframer_top_tb;

    import rdsd_pkg::*;

    localparam int    MAX_GAP          = 17;
    localparam int    HOLD_OFF_CYCLES  = 250;
    localparam int    DRAIN_CYCLES     = 2 * MAX_GAP + 8;
    localparam int    ITEM_GOAL        = 1950;
    localparam int    DIRECTED_ROWS    = 23;

    // how a stimulus row gets its expectation
    typedef enum logic [1:0] {
        ROW_PREDICT,   // predictor decides
        ROW_NONE,      // typed in: byte produces nothing
        ROW_RESULT     // typed in: byte produces the given result
    } row_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] raw;
        row_mode_t         mode;
        rdsd_result_t      res;
    } stim_row_t;

    // directed opener: escapes, repeated escape, both frame lengths at the
    // short end, start marker as payload, last byte with and without end marker
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, ROW_NONE,    '0},                          // dropped while hunting
        '{8'hfd, ROW_NONE,    '0},
        '{8'hfd, ROW_NONE,    '0},                          // repeated escape
        '{8'h01, ROW_RESULT,  '{8'hfe, 9'd0, 1'b0, 1'b0}},  // escaped start marker
        '{8'h12, ROW_PREDICT, '0},
        '{8'hfd, ROW_NONE,    '0},
        '{8'h00, ROW_RESULT,  '{8'hfd, 9'd2, 1'b0, 1'b0}},
        '{8'hfd, ROW_NONE,    '0},
        '{8'h05, ROW_RESULT,  '{8'hff, 9'd3, 1'b0, 1'b0}},
        '{8'h00, ROW_RESULT,  '{8'h00, 9'd4, 1'b0, 1'b0}},  // length 0, eight bytes
        '{8'h7f, ROW_PREDICT, '0},
        '{8'h80, ROW_PREDICT, '0},
        '{8'hff, ROW_RESULT,  '{8'hff, 9'd7, 1'b1, 1'b1}},  // last, end marker ok
        '{8'hff, ROW_NONE,    '0},                          // hunting again
        '{8'hfe, ROW_RESULT,  '{8'hfe, 9'd0, 1'b0, 1'b0}},
        '{8'h01, ROW_PREDICT, '0},
        '{8'h02, ROW_PREDICT, '0},
        '{8'h03, ROW_PREDICT, '0},
        '{8'h01, ROW_RESULT,  '{8'h01, 9'd4, 1'b0, 1'b0}},  // length 1, nine bytes
        '{8'haa, ROW_PREDICT, '0},
        '{8'h55, ROW_PREDICT, '0},
        '{8'hfe, ROW_PREDICT, '0},                          // start marker as payload
        '{8'h00, ROW_RESULT,  '{8'h00, 9'd8, 1'b1, 1'b0}}   // last, no end marker
    };

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    logic                    m_tuser;

    // predictor state
    logic                    esc_armed;
    logic                    in_frame;
    int                      next_pos;
    int                      frame_len;

    stim_row_t               stim_q[$];
    rdsd_result_t            pending_frame_bytes[$];
    int                      results_seen;
    int                      mismatches;

    rds_byte_destuff_deframer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // destuff one raw byte and track frame position; returns 1 when a frame
    // byte comes out
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] raw,
                                        output rdsd_result_t res);
        logic [BYTE_W-1:0] b;
        int                pos;
        res = '0;
        b   = raw;
        if (raw == ESC_BYTE)
        begin
            esc_armed = 1'b1;
            return 1'b0;
        end
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            if (raw == STUFF_FD)
            begin
                b = ESC_BYTE;
            end
            else if (raw == STUFF_FE)
            begin
                b = START_MARK;
            end
            else
            begin
                b = END_MARK;
            end
        end
        if (!in_frame)
        begin
            if (b != START_MARK)
            begin
                return 1'b0;
            end
            in_frame  = 1'b1;
            next_pos  = 0;
            frame_len = 0;
        end
        pos = next_pos;
        if (pos == int'(LEN_POS))
        begin
            frame_len = int'(b) + int'(LEN_EXTRA);
        end
        res.frame_byte    = b;
        res.byte_position = pos[POS_W-1:0];
        if (pos >= int'(LEN_POS) && pos + 1 >= frame_len)
        begin
            res.last_of_frame = 1'b1;
            res.end_marker_ok = (b == END_MARK);
            in_frame          = 1'b0;
            next_pos          = 0;
        end
        else
        begin
            next_pos = pos + 1;
        end
        return 1'b1;
    endfunction

    function automatic void add_raw(input logic [BYTE_W-1:0] b);
        stim_row_t r;
        r      = '0;
        r.raw  = b;
        r.mode = ROW_PREDICT;
        stim_q.push_back(r);
    endfunction

    // escape prefix, sometimes doubled
    function automatic void add_escape(input logic [BYTE_W-1:0] code);
        if ($urandom_range(0, 7) == 0)
        begin
            add_raw(ESC_BYTE);
        end
        add_raw(ESC_BYTE);
        add_raw(code);
    endfunction

    // one frame byte on the wire; reserved codes mostly go out escaped
    function automatic void add_stuffed(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] other;
        if (b == ESC_BYTE)
        begin
            add_escape(STUFF_FD);
        end
        else if (b == START_MARK && $urandom_range(0, 3) != 0)
        begin
            add_escape(STUFF_FE);
        end
        else if (b == END_MARK && $urandom_range(0, 3) != 0)
        begin
            // any escaped value other than the two codes decodes to 0xff
            do
            begin
                other = BYTE_W'($urandom_range(2, 255));
            end
            while (other == ESC_BYTE);
            add_escape(other);
        end
        else
        begin
            add_raw(b);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_payload_byte();
        logic [BYTE_W-1:0] b;
        case ($urandom_range(0, 11))
            0:       b = ESC_BYTE;
            1:       b = START_MARK;
            2:       b = END_MARK;
            3:       b = STUFF_FD;
            4:       b = STUFF_FE;
            default: b = BYTE_W'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // well-formed frame with random content, or a truncated one
    function automatic void add_frame(input bit full_len, input bit broken);
        int len;
        int cut;
        if (full_len)
        begin
            len = 255;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(0, 40);
        end
        else
        begin
            len = $urandom_range(0, 6);
        end
        add_stuffed(START_MARK);
        if (broken)
        begin
            // the next start marker may land inside this frame as payload
            cut = $urandom_range(0, 10);
            repeat (cut) add_stuffed(pick_payload_byte());
            return;
        end
        repeat (3) add_stuffed(pick_payload_byte());
        add_stuffed(len[BYTE_W-1:0]);
        repeat (len + 2) add_stuffed(pick_payload_byte());
        add_stuffed(($urandom_range(0, 3) == 0) ? pick_payload_byte() : END_MARK);
    endfunction

    // line noise between frames, rarely containing a start marker
    function automatic void add_noise();
        logic [BYTE_W-1:0] b;
        int                n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == START_MARK && $urandom_range(0, 7) != 0)
            begin
                b = 8'h00;
            end
            add_raw(b);
        end
    endfunction

    // offer one byte after a random gap (none when quiet) and book its expectation on acceptance
    task automatic offer_byte(input stim_row_t row, input bit quiet);
        int           gap;
        bit           produced;
        rdsd_result_t pred;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.raw;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        produced = deframe_byte(row.raw, pred);
        case (row.mode)
            ROW_PREDICT:
            begin
                if (produced)
                begin
                    pending_frame_bytes.push_back(pred);
                end
            end
            ROW_RESULT: pending_frame_bytes.push_back(row.res);
            default:    ;
        endcase
    endtask

    task automatic check_result(input rdsd_result_t got);
        rdsd_result_t want;
        if (pending_frame_bytes.size() == 0)
        begin
            $error("unexpected result: frame_byte %h byte_position %0d",
                   got.frame_byte, got.byte_position);
            mismatches++;
            return;
        end
        want = pending_frame_bytes.pop_front();
        if (got.frame_byte !== want.frame_byte)
        begin
            $error("frame_byte: expected %h, got %h", want.frame_byte, got.frame_byte);
            mismatches++;
        end
        if (got.byte_position !== want.byte_position)
        begin
            $error("byte_position: expected %0d, got %0d",
                   want.byte_position, got.byte_position);
            mismatches++;
        end
        if (got.last_of_frame !== want.last_of_frame)
        begin
            $error("last_of_frame: expected %b, got %b",
                   want.last_of_frame, got.last_of_frame);
            mismatches++;
        end
        if (got.end_marker_ok !== want.end_marker_ok)
        begin
            $error("end_marker_ok: expected %b, got %b",
                   want.end_marker_ok, got.end_marker_ok);
            mismatches++;
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int frame_no;
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        m_tready         = 1'b0;
        esc_armed        = 1'b0;
        in_frame         = 1'b0;
        next_pos         = 0;
        frame_len        = 0;
        results_seen     = 0;
        mismatches       = 0;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            stim_q.push_back(DIRECTED[i]);
        end
        frame_no = 0;
        while (stim_q.size() < ITEM_GOAL)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_noise();
            end
            add_frame(frame_no == 20 || frame_no == 40,
                      frame_no != 20 && frame_no != 40 && $urandom_range(0, 11) == 0);
            frame_no++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles in stretches, with every third stretch running flat out
        for (int i = 0; i < stim_q.size(); i++)
        begin
            offer_byte(stim_q[i], ((i / 128) % 3) == 2);
        end
        s_tvalid <= 1'b0;

        while (pending_frame_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // result sink with random stalls and two long hold-offs that back up the input
    initial
    begin
        int           stall;
        rdsd_result_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = (((results_seen / 90) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
            if (results_seen == 150 || results_seen == 900)
            begin
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            got.frame_byte    = m_tdata[7:0];
            got.byte_position = m_tdata[16:8];
            got.last_of_frame = m_tlast;
            got.end_marker_ok = m_tuser;
            check_result(got);
            results_seen++;
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> rds_byte_destuff_deframer_top.f
hdl/rdsd_pkg.sv
hdl/rdsd_frame_core.sv
hdl/rdsd_out_buf.sv
hdl/rds_byte_destuff_deframer_top.sv
tb/rds_byte_destuff_deframer_top_tb.sv
